// File: rtl/core/register_file_alu_executor_core_assert.svh
// Assertion macros shared by the register file ALU executor core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef REGISTER_FILE_ALU_EXECUTOR_CORE_ASSERT_SVH
`define REGISTER_FILE_ALU_EXECUTOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFAE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rfae_pkg.sv
// Shared types, codes and constants of the register file ALU executor core.
// Depends on nothing; every module of the core but rfae_ram imports it.
package rfae_pkg;

  localparam int unsigned NUM_REGS_DEF = 26;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned OP_W         = 4;
  localparam int unsigned CNT_W        = $clog2(DATA_W);

  // Instruction operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 4'd0,
    OP_OUT  = 4'd1,
    OP_MOVE = 4'd2,
    OP_XCHG = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_MUL  = 4'd6,
    OP_DIV  = 4'd7,
    OP_MOD  = 4'd8,
    OP_AND  = 4'd9,
    OP_OR   = 4'd10,
    OP_XOR  = 4'd11
  } op_e;

  // Result kinds.
  localparam logic RK_VALUE    = 1'b0;
  localparam logic RK_DIV_ZERO = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD2,
    S_GOT,
    S_XCH2,
    S_WAIT,
    S_OUT
  } seq_state_e;

  // Shared arithmetic unit states.
  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_ABS_A,
    A_ABS_B,
    A_DIV,
    A_FIX
  } alu_state_e;

  // One decoded instruction.
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [IDX_W-1:0]         dest_reg;
    logic [IDX_W-1:0]         first_src;
    logic [IDX_W-1:0]         second_src;
    logic                     three_operand;
    logic signed [DATA_W-1:0] immediate;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic                     result_kind;
    logic signed [DATA_W-1:0] result_value;
  } out_item_t;

  // Register file access from the sequencer.
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] wr_data;
  } rf_req_t;

  // Command to the shared arithmetic unit.
  typedef struct packed {
    logic              start;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } alu_req_t;

  // Completion from the shared arithmetic unit.
  typedef struct packed {
    logic              done;
    logic              div_zero;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// File: rtl/core/rfae_ram.sv
// Generic single write port RAM with one registered read port.
// Depends on nothing; holds the register file of the executor core.
module rfae_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rfae_alu.sv
// Shared iterative arithmetic unit: one 64-bit adder serves add, subtract,
// shift-add multiply, operand magnitudes, restoring divide and sign fix-up. Imports rfae_pkg.
`include "register_file_alu_executor_core_assert.svh"

module rfae_alu
  import rfae_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  alu_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              dz_q, dz_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] opa_q, opa_d;
  logic [DATA_W-1:0] opb_q, opb_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic              rem_q, rem_d;
  logic              neg_q, neg_d;

  logic [DATA_W-1:0] add_a, add_b;
  logic              add_sub;
  logic [DATA_W:0]   add_sum;
  logic [DATA_W-1:0] add_res;
  logic              add_carry;

  // The one shared adder; with add_sub set it computes add_a - add_b and the
  // carry out is high when no borrow occurred.
  assign add_sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{DATA_W{1'b0}}, add_sub};
  assign add_res   = add_sum[DATA_W-1:0];
  assign add_carry = add_sum[DATA_W];

  // Sequencing of the unit and selection of the adder operands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    dz_d    = 1'b0;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    res_d   = res_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_ADD: begin
              add_a  = req_i.x;
              add_b  = req_i.y;
              res_d  = add_res;
              done_d = 1'b1;
            end
            OP_SUB: begin
              add_a   = req_i.x;
              add_b   = req_i.y;
              add_sub = 1'b1;
              res_d   = add_res;
              done_d  = 1'b1;
            end
            OP_AND: begin
              res_d  = req_i.x & req_i.y;
              done_d = 1'b1;
            end
            OP_OR: begin
              res_d  = req_i.x | req_i.y;
              done_d = 1'b1;
            end
            OP_XOR: begin
              res_d  = req_i.x ^ req_i.y;
              done_d = 1'b1;
            end
            OP_MUL: begin
              opa_d   = req_i.x;
              opb_d   = req_i.y;
              acc_d   = '0;
              state_d = A_MUL;
            end
            OP_DIV, OP_MOD: begin
              if (req_i.y == '0) begin
                res_d  = '0;
                dz_d   = 1'b1;
                done_d = 1'b1;
              end else begin
                opa_d   = req_i.x;
                opb_d   = req_i.y;
                acc_d   = '0;
                rem_d   = (req_i.op == OP_MOD);
                neg_d   = (req_i.op == OP_MOD) ? req_i.x[DATA_W-1]
                                               : (req_i.x[DATA_W-1] ^ req_i.y[DATA_W-1]);
                state_d = A_ABS_A;
              end
            end
            default: begin
              res_d  = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      // One multiplier bit per cycle; the product wraps to 64 bits.
      A_MUL: begin
        add_a = acc_q;
        add_b = opb_q[0] ? opa_q : '0;
        acc_d = add_res;
        opa_d = {opa_q[DATA_W-2:0], 1'b0};
        opb_d = {1'b0, opb_q[DATA_W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          res_d   = add_res;
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      // Take the magnitude of the dividend.
      A_ABS_A: begin
        add_b   = opa_q;
        add_sub = 1'b1;
        if (opa_q[DATA_W-1]) begin
          opa_d = add_res;
        end
        state_d = A_ABS_B;
      end
      // Take the magnitude of the divisor.
      A_ABS_B: begin
        add_b   = opb_q;
        add_sub = 1'b1;
        if (opb_q[DATA_W-1]) begin
          opb_d = add_res;
        end
        state_d = A_DIV;
      end
      // Restoring division, one quotient bit per cycle.
      A_DIV: begin
        add_a   = {acc_q[DATA_W-2:0], opa_q[DATA_W-1]};
        add_b   = opb_q;
        add_sub = 1'b1;
        acc_d   = add_carry ? add_res : add_a;
        opa_d   = {opa_q[DATA_W-2:0], add_carry};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = A_FIX;
        end
      end
      // Apply the sign to the quotient or the remainder.
      A_FIX: begin
        add_b   = rem_q ? acc_q : opa_q;
        add_sub = 1'b1;
        res_d   = neg_q ? add_res : add_b;
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      dz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      dz_q    <= dz_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    res_q <= res_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.div_zero = dz_q;
  assign rsp_o.result   = res_q;

  `RFAE_ASSERT_NOW(a_cnt_idle_zero, clk_i, rst_ni, state_q == A_IDLE, cnt_q == '0, "iteration count not zero while idle")
  `RFAE_ASSERT_NOW(a_dz_zero_result, clk_i, rst_ni, done_q && dz_q, res_q == '0, "divide by zero result not zero")
  `RFAE_ASSERT_NEXT(a_fix_done, clk_i, rst_ni, state_q == A_FIX, done_q && !dz_q, "divide did not complete after sign fix")

endmodule

// File: rtl/core/rfae_seq.sv
// Instruction sequencer: reads operands, drives the shared arithmetic unit,
// writes results back and presents output transactions. Imports rfae_pkg.
`include "register_file_alu_executor_core_assert.svh"

module rfae_seq
  import rfae_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  output rf_req_t           rf_req_o,
  input  logic [DATA_W-1:0] rd_data_i,
  output alu_req_t          alu_req_o,
  input  alu_rsp_t          alu_rsp_i
);

  seq_state_e        state_q, state_d;
  in_item_t          item_q, item_d;
  logic [DATA_W-1:0] x_q, x_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic accept;
  logic in_alu;
  logic in_known;
  logic item_alu;
  logic out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign in_alu   = (in_item_i.operation >= OP_ADD) && (in_item_i.operation <= OP_XOR);
  assign in_known = (in_item_i.operation <= OP_XOR);
  assign item_alu = (item_q.operation >= OP_ADD) && (item_q.operation <= OP_XOR);

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and control for one instruction at a time.
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    x_d         = x_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rf_req_o    = '0;
    alu_req_o   = '0;
    case (state_q)
      // Take the transaction and start the first operand read.
      S_IDLE: begin
        if (in_valid_i) begin
          item_d         = in_item_i;
          rf_req_o.rd_en = 1'b1;
          if ((in_item_i.operation == OP_OUT) || (in_item_i.operation == OP_XCHG) ||
              (in_alu && !in_item_i.three_operand)) begin
            rf_req_o.rd_idx = in_item_i.dest_reg;
          end else begin
            rf_req_o.rd_idx = in_item_i.first_src;
          end
          if (in_known) begin
            state_d = S_RD2;
          end
        end
      end
      // First operand is here; finish simple operations or read the second.
      S_RD2: begin
        x_d = rd_data_i;
        case (item_q.operation)
          OP_LOAD: begin
            rf_req_o.wr_en   = 1'b1;
            rf_req_o.wr_idx  = item_q.dest_reg;
            rf_req_o.wr_data = item_q.immediate;
            state_d          = S_IDLE;
          end
          OP_OUT: begin
            state_d = S_OUT;
          end
          OP_MOVE: begin
            rf_req_o.wr_en   = 1'b1;
            rf_req_o.wr_idx  = item_q.dest_reg;
            rf_req_o.wr_data = rd_data_i;
            state_d          = S_IDLE;
          end
          OP_XCHG: begin
            rf_req_o.rd_en  = 1'b1;
            rf_req_o.rd_idx = item_q.first_src;
            state_d         = S_GOT;
          end
          default: begin
            if (item_alu) begin
              rf_req_o.rd_en  = 1'b1;
              rf_req_o.rd_idx = item_q.three_operand ? item_q.second_src : item_q.first_src;
              state_d         = S_GOT;
            end else begin
              state_d = S_IDLE;
            end
          end
        endcase
      end
      // Second operand is here.
      S_GOT: begin
        if (item_q.operation == OP_XCHG) begin
          rf_req_o.wr_en   = 1'b1;
          rf_req_o.wr_idx  = item_q.dest_reg;
          rf_req_o.wr_data = rd_data_i;
          state_d          = S_XCH2;
        end else begin
          alu_req_o.start = 1'b1;
          alu_req_o.op    = item_q.operation;
          alu_req_o.x     = x_q;
          alu_req_o.y     = rd_data_i;
          state_d         = S_WAIT;
        end
      end
      // Second half of an exchange.
      S_XCH2: begin
        rf_req_o.wr_en   = 1'b1;
        rf_req_o.wr_idx  = item_q.first_src;
        rf_req_o.wr_data = x_q;
        state_d          = S_IDLE;
      end
      // Wait for the arithmetic unit, then write back or report the error.
      S_WAIT: begin
        if (alu_rsp_i.done) begin
          if (alu_rsp_i.div_zero) begin
            state_d = S_OUT;
          end else begin
            rf_req_o.wr_en   = 1'b1;
            rf_req_o.wr_idx  = item_q.dest_reg;
            rf_req_o.wr_data = alu_rsp_i.result;
            state_d          = S_IDLE;
          end
        end
      end
      // Move the result into the output register once it is free.
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (item_q.operation == OP_OUT) begin
            out_d.result_kind  = RK_VALUE;
            out_d.result_value = x_q;
          end else begin
            out_d.result_kind  = RK_DIV_ZERO;
            out_d.result_value = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Instruction, operand and result registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    x_q    <= x_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `RFAE_ASSERT_NOW(a_xch_order, clk_i, rst_ni, state_q == S_XCH2, $past(state_q) == S_GOT, "second exchange write without the first")
  `RFAE_ASSERT_NOW(a_alu_start, clk_i, rst_ni, accept && in_alu, ##2 alu_req_o.start, "arithmetic instruction did not start the unit")
  `RFAE_ASSERT_NEXT(a_out_load, clk_i, rst_ni, (state_q == S_OUT) && out_free, out_valid_o, "result not loaded")
  `RFAE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result changed")

endmodule

// File: rtl/core/register_file_alu_executor_core.sv
// Top level of the register file ALU executor core: register file with
// per-entry valid bits, sequencer and shared arithmetic unit. Imports rfae_pkg.

// The core executes one decoded instruction per input transaction on NumRegs
// signed 64-bit registers that read as zero after reset; register indexes at
// or beyond NumRegs read as zero and are never written. It works on one
// instruction at a time and stalls its input until that instruction is done.
// Multiply and divide run one bit per cycle through a single 64-bit adder, so
// they hold the input off longer than loads, moves, exchanges, outputs, add,
// subtract and the logic operations. Results go to an output register, so a
// stalled output only holds the input off when a second result is ready while
// the first still waits. An output result is read into the sequencer and then
// loaded into the output register from state S_OUT; a divide or modulo by zero
// goes through S_WAIT and S_OUT before its error result is presented.
module register_file_alu_executor_core
  import rfae_pkg::*;
#(
  parameter int unsigned NumRegs = NUM_REGS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AddrW = $clog2(NumRegs);
  localparam int unsigned SlotN = 1 << AddrW;

  rf_req_t           rf_req;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] rd_data;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic              rd_ok;
  logic              wr_ok;
  logic [SlotN-1:0]  live_q;
  logic              rd_live_q;

  // Range checks on register indexes.
  assign rd_ok   = ({1'b0, rf_req.rd_idx} < (IDX_W+1)'(NumRegs));
  assign wr_ok   = ({1'b0, rf_req.wr_idx} < (IDX_W+1)'(NumRegs));
  assign rd_addr = rf_req.rd_idx[AddrW-1:0];
  assign wr_addr = rf_req.wr_idx[AddrW-1:0];

  // Valid bit per register: an unwritten register reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      rd_live_q <= 1'b0;
    end else begin
      if (rf_req.wr_en && wr_ok) begin
        live_q[wr_addr] <= 1'b1;
      end
      if (rf_req.rd_en) begin
        rd_live_q <= rd_ok && live_q[rd_addr];
      end
    end
  end

  rfae_ram #(
    .Width (DATA_W),
    .Depth (NumRegs)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (rf_req.wr_en && wr_ok),
    .waddr_i (wr_addr),
    .wdata_i (rf_req.wr_data),
    .re_i    (rf_req.rd_en && rd_ok),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Masked read data for the sequencer.
  assign rd_data = rd_live_q ? ram_rdata : '0;

  rfae_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .rf_req_o    (rf_req),
    .rd_data_i   (rd_data),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp)
  );

  rfae_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

endmodule

// File: bench/register_file_alu_executor_core_tb.sv
// Self-checking testbench for register_file_alu_executor_core.
// It predicts every result on a shadow register file and depends only on rfae_pkg and the core.
`timescale 1ns / 1ps

module register_file_alu_executor_core_tb;
  import rfae_pkg::*;

  localparam int unsigned NUM_REGS     = NUM_REGS_DEF;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [OP_W-1:0]   OP_UNUSED_LO = 4'd12;
  localparam logic [OP_W-1:0]   OP_UNUSED_HI = 4'd15;
  localparam logic [DATA_W-1:0] MOST_NEG     = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] MOST_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_e;
  typedef enum logic {TX_STREAM, TX_BURSTY} tx_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  // Shadow copy of the register file and the results it still owes.
  logic [DATA_W-1:0] shadow_regs [NUM_REGS];
  out_item_t         pending_outputs [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned rx_phase       = 0;
  rx_mode_e    rx_mode        = RX_FREE;
  tx_mode_e    tx_mode        = TX_STREAM;

  register_file_alu_executor_core #(
    .NumRegs(NUM_REGS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Out-of-range indexes read as zero and drop writes.
  function automatic logic [DATA_W-1:0] read_shadow(logic [IDX_W-1:0] idx);
    return (idx < NUM_REGS) ? shadow_regs[idx] : '0;
  endfunction

  function automatic void write_shadow(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    if (idx < NUM_REGS) begin
      shadow_regs[idx] = value;
    end
  endfunction

  // Executes one instruction on the shadow file and queues any result it produces.
  function automatic void execute_on_shadow(in_item_t instr);
    logic [DATA_W-1:0] x, y, t, mag_x, mag_y, quot, rem;
    out_item_t         res;
    res = '0;
    case (instr.operation)
      OP_LOAD: begin
        write_shadow(instr.dest_reg, instr.immediate);
      end
      OP_OUT: begin
        res.result_kind  = RK_VALUE;
        res.result_value = read_shadow(instr.dest_reg);
        pending_outputs.push_back(res);
      end
      OP_MOVE: begin
        write_shadow(instr.dest_reg, read_shadow(instr.first_src));
      end
      OP_XCHG: begin
        t = read_shadow(instr.dest_reg);
        x = read_shadow(instr.first_src);
        write_shadow(instr.dest_reg, x);
        write_shadow(instr.first_src, t);
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR: begin
        if (instr.three_operand) begin
          x = read_shadow(instr.first_src);
          y = read_shadow(instr.second_src);
        end else begin
          x = read_shadow(instr.dest_reg);
          y = read_shadow(instr.first_src);
        end
        if ((instr.operation == OP_DIV || instr.operation == OP_MOD) && y == '0) begin
          // Division by zero reports an error and leaves the destination alone.
          res.result_kind  = RK_DIV_ZERO;
          res.result_value = '0;
          pending_outputs.push_back(res);
        end else begin
          mag_x = x[DATA_W-1] ? ('0 - x) : x;
          mag_y = y[DATA_W-1] ? ('0 - y) : y;
          quot  = (mag_y != '0) ? mag_x / mag_y : '0;
          rem   = (mag_y != '0) ? mag_x % mag_y : '0;
          case (instr.operation)
            OP_ADD:  t = x + y;
            OP_SUB:  t = x - y;
            OP_MUL:  t = x * y;
            OP_DIV:  t = (x[DATA_W-1] ^ y[DATA_W-1]) ? ('0 - quot) : quot;
            OP_MOD:  t = x[DATA_W-1] ? ('0 - rem) : rem;
            OP_AND:  t = x & y;
            OP_OR:   t = x | y;
            default: t = x ^ y;
          endcase
          write_shadow(instr.dest_reg, t);
        end
      end
      default: begin
        // Unused operation codes do nothing.
      end
    endcase
  endfunction

  function automatic in_item_t make_instr(logic [OP_W-1:0] op, logic [IDX_W-1:0] dst,
                                          logic [IDX_W-1:0] src_a, logic [IDX_W-1:0] src_b,
                                          logic three, logic [DATA_W-1:0] imm);
    in_item_t instr;
    instr.operation     = op;
    instr.dest_reg      = dst;
    instr.first_src     = src_a;
    instr.second_src    = src_b;
    instr.three_operand = three;
    instr.immediate     = imm;
    return instr;
  endfunction

  // Mostly in-range register indexes, now and then one at or beyond the end of the file.
  function automatic logic [IDX_W-1:0] pick_reg();
    if ($urandom_range(0, 9) == 0) begin
      return IDX_W'($urandom_range(NUM_REGS, 31));
    end
    return IDX_W'($urandom_range(0, NUM_REGS - 1));
  endfunction

  // Operand values biased toward the corners of signed 64-bit arithmetic.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 64'd1;
      2:       return ALL_ONES;
      3:       return MOST_NEG;
      4:       return MOST_POS;
      5:       return 64'($urandom_range(0, 40)) - 64'd20;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sends one transaction; in bursty mode it inserts a random gap at the start of each burst.
  task automatic send_item(input in_item_t instr);
    int unsigned gap;
    if (tx_mode == TX_BURSTY) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
        burst_left = $urandom_range(1, 10);
        repeat (gap) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = instr;
    do begin
      @(posedge clk);
    end while (in_stall);
    execute_on_shadow(instr);
    if (instr.operation <= OP_XOR) begin
      items_sent++;
    end
  endtask

  // Receiver stall: a long hold-off on request, otherwise the selected pattern.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    rx_phase++;
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_RANDOM:   out_stall = ($urandom_range(0, 99) < 35);
        RX_PERIODIC: out_stall = ((rx_phase % 7) < 3);
        default:     out_stall = 1'b0;
      endcase
    end
  end

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // Compare each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        note_failure($sformatf("unexpected result kind %0b value %h",
                               out_item.result_kind, out_item.result_value));
      end else begin
        want = pending_outputs.pop_front();
        if (out_item.result_kind !== want.result_kind) begin
          note_failure($sformatf("result_kind expected %0b actual %0b",
                                 want.result_kind, out_item.result_kind));
        end
        if (out_item.result_value !== want.result_value) begin
          note_failure($sformatf("result_value expected %h actual %h",
                                 want.result_value, out_item.result_value));
        end
      end
    end
  end

  // Registers read as zero after reset; indexes past the file ignore writes.
  task automatic test_reset_and_bounds();
    rx_mode = RX_FREE;
    tx_mode = TX_STREAM;
    send_item(make_instr(OP_OUT, 5'd5, '0, '0, 1'b0, '0));
    send_item(make_instr(OP_LOAD, 5'd31, '0, '0, 1'b1, 64'h0123_4567_89AB_CDEF));
    send_item(make_instr(OP_OUT, 5'd31, '0, '0, 1'b0, '0));
  endtask

  // Signed corners: wrap on overflow, most negative over minus one, truncation.
  task automatic test_arithmetic_extremes();
    rx_mode = RX_RANDOM;
    tx_mode = TX_BURSTY;
    send_item(make_instr(OP_LOAD, 5'd0, '0, '0, 1'b0, MOST_NEG));
    send_item(make_instr(OP_LOAD, 5'd1, '0, '0, 1'b0, ALL_ONES));
    send_item(make_instr(OP_LOAD, 5'd2, '0, '0, 1'b0, MOST_POS));
    send_item(make_instr(OP_LOAD, 5'd13, '0, '0, 1'b0, 64'd0 - 64'd7));
    send_item(make_instr(OP_LOAD, 5'd14, '0, '0, 1'b0, 64'd2));
    send_item(make_instr(OP_DIV, 5'd3, 5'd0, 5'd1, 1'b1, '0));
    send_item(make_instr(OP_MOD, 5'd4, 5'd0, 5'd1, 1'b1, '0));
    send_item(make_instr(OP_MUL, 5'd7, 5'd2, 5'd2, 1'b1, '0));
    send_item(make_instr(OP_ADD, 5'd8, 5'd2, 5'd2, 1'b1, '0));
    send_item(make_instr(OP_SUB, 5'd9, 5'd0, 5'd2, 1'b1, '0));
    send_item(make_instr(OP_AND, 5'd10, 5'd0, 5'd1, 1'b1, '0));
    send_item(make_instr(OP_OR, 5'd10, 5'd2, '0, 1'b0, '0));
    send_item(make_instr(OP_XOR, 5'd11, 5'd2, 5'd1, 1'b1, '0));
    send_item(make_instr(OP_DIV, 5'd15, 5'd13, 5'd14, 1'b1, '0));
    send_item(make_instr(OP_MOD, 5'd16, 5'd13, 5'd14, 1'b1, '0));
    send_item(make_instr(OP_OUT, 5'd3, '0, '0, 1'b0, '0));
    send_item(make_instr(OP_OUT, 5'd16, '0, '0, 1'b0, '0));
  endtask

  // Division and remainder by zero, including a divisor index past the file.
  task automatic test_divide_by_zero();
    rx_mode = RX_PERIODIC;
    tx_mode = TX_STREAM;
    send_item(make_instr(OP_DIV, 5'd2, 5'd5, '0, 1'b0, '0));
    send_item(make_instr(OP_MOD, 5'd6, 5'd2, 5'd30, 1'b1, '0));
    send_item(make_instr(OP_OUT, 5'd2, '0, '0, 1'b0, '0));
  endtask

  // Move and exchange ignore the form bit; unused codes leave no trace.
  task automatic test_moves_and_unused();
    logic [OP_W-1:0] code;
    rx_mode = RX_FREE;
    tx_mode = TX_BURSTY;
    send_item(make_instr(OP_MOVE, 5'd12, 5'd0, 5'd1, 1'b1, ALL_ONES));
    send_item(make_instr(OP_XCHG, 5'd12, 5'd2, 5'd3, 1'b1, '0));
    send_item(make_instr(OP_XCHG, 5'd3, 5'd3, '0, 1'b0, '0));
    for (code = OP_UNUSED_LO; code != '0; code++) begin
      send_item(make_instr(code, 5'd12, 5'd0, 5'd1, code[0], MOST_POS));
    end
    send_item(make_instr(OP_OUT, 5'd12, '0, '0, 1'b0, '0));
  endtask

  // A long receiver hold-off while the sender keeps offering transactions.
  task automatic test_output_backpressure();
    rx_mode      = RX_FREE;
    tx_mode      = TX_STREAM;
    hold_request = HOLD_CYCLES;
    send_item(make_instr(OP_OUT, 5'd0, '0, '0, 1'b0, '0));
    send_item(make_instr(OP_OUT, 5'd1, '0, '0, 1'b0, '0));
    send_item(make_instr(OP_MUL, 5'd20, 5'd1, 5'd2, 1'b1, '0));
    send_item(make_instr(OP_OUT, 5'd20, '0, '0, 1'b0, '0));
    send_item(make_instr(OP_LOAD, 5'd21, '0, '0, 1'b0, 64'hDEAD_BEEF_0000_0001));
    send_item(make_instr(OP_OUT, 5'd21, '0, '0, 1'b0, '0));
  endtask

  // Short programs with random content, mixed with unconstrained noise.
  task automatic test_random_programs();
    int unsigned     start_count;
    logic [IDX_W-1:0] ra, rb, rd;
    logic [OP_W-1:0]  alu_op;
    int unsigned     idx;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        tx_mode = tx_mode_e'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 4) != 0) begin
        ra = pick_reg();
        rb = pick_reg();
        rd = pick_reg();
        send_item(make_instr(OP_LOAD, ra, pick_reg(), pick_reg(), 1'($urandom), pick_value()));
        send_item(make_instr(OP_LOAD, rb, pick_reg(), pick_reg(), 1'($urandom), pick_value()));
        case ($urandom_range(0, 9))
          0:       send_item(make_instr(OP_MOVE, rd, ra, rb, 1'($urandom), {$urandom, $urandom}));
          1:       send_item(make_instr(OP_XCHG, rd, ra, rb, 1'($urandom), {$urandom, $urandom}));
          default: begin
            alu_op = OP_ADD + OP_W'($urandom_range(0, 7));
            send_item(make_instr(alu_op, rd, ra, rb, 1'($urandom), {$urandom, $urandom}));
          end
        endcase
        if ($urandom_range(0, 9) < 7) begin
          send_item(make_instr(OP_OUT, rd, pick_reg(), pick_reg(), 1'($urandom), '0));
        end
      end else begin
        send_item(make_instr(OP_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 31)),
                             IDX_W'($urandom_range(0, 31)), IDX_W'($urandom_range(0, 31)),
                             1'($urandom), {$urandom, $urandom}));
      end
    end
    // Read back the whole index space so any stray write shows up.
    for (idx = 0; idx < 32; idx++) begin
      send_item(make_instr(OP_OUT, IDX_W'(idx), '0, '0, 1'b0, '0));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) begin
      shadow_regs[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_and_bounds();
    test_arithmetic_extremes();
    test_divide_by_zero();
    test_moves_and_unused();
    test_output_backpressure();
    test_random_programs();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rfae_pkg.sv
rtl/core/rfae_ram.sv
rtl/core/rfae_alu.sv
rtl/core/rfae_seq.sv
rtl/core/register_file_alu_executor_core.sv
bench/register_file_alu_executor_core_tb.sv
